FILE: rtl/gdn_pkg.sv
// shared constants, calendar tables and helper functions for the day number converter
// no dependencies; used by gdn_encode, gdn_decode and gregorian_day_number_convert
package gdn_pkg;

  localparam int unsigned MaxYearInt = 9999;
  localparam int unsigned BaseYearInt = 1601;

  localparam logic [13:0] MaxYear  = 14'(MaxYearInt);
  localparam logic [13:0] BaseYear = 14'(BaseYearInt);

  // years elapsed up to jan 1 after the last supported year
  localparam int unsigned LastSpan = MaxYearInt + 1 - BaseYearInt;
  localparam logic [22:0] LastDay  = 23'(365 * LastSpan + LastSpan / 4 - LastSpan / 100
                                         + LastSpan / 400);

  // reciprocal multipliers: x / c == (x * Recip) >> Shift over the value ranges used here
  localparam int unsigned Recip100Shift = 19;
  localparam logic [12:0] Recip100 = 13'(((64'd1 << Recip100Shift) + 64'd99) / 64'd100);
  localparam int unsigned RecipYearShift = 30;
  // rounded down, so the year estimate is never above the true year
  localparam logic [21:0] RecipYear = 22'((64'd1 << RecipYearShift) * 64'd400 / 64'd146097);
  localparam int unsigned Recip7Shift = 25;
  localparam logic [22:0] Recip7 = 23'(((64'd1 << Recip7Shift) + 64'd6) / 64'd7);

  localparam int unsigned EncStages = 3;
  localparam int unsigned DecStages = 8;
  localparam int unsigned NStages   = EncStages + DecStages;

  // days in the months before month m of a common year; months past twelve add 31 each
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] c;
    case (m)
      4'd0, 4'd1: c = 9'd0;
      4'd2:       c = 9'd31;
      4'd3:       c = 9'd59;
      4'd4:       c = 9'd90;
      4'd5:       c = 9'd120;
      4'd6:       c = 9'd151;
      4'd7:       c = 9'd181;
      4'd8:       c = 9'd212;
      4'd9:       c = 9'd243;
      4'd10:      c = 9'd273;
      4'd11:      c = 9'd304;
      4'd12:      c = 9'd334;
      4'd13:      c = 9'd365;
      4'd14:      c = 9'd396;
      default:    c = 9'd427;
    endcase
    return c;
  endfunction

  function automatic logic [8:0] cum_days_leap(input logic [3:0] m, input logic leap);
    return cum_days(m) + 9'((leap && (m >= 4'd3)) ? 1 : 0);
  endfunction

  // leap test from a year j and its hundreds q = j / 100
  function automatic logic is_leap(input logic [13:0] j, input logic [7:0] q);
    logic [13:0] rem;
    rem = j - 14'(q) * 14'd100;
    return (j[1:0] == 2'd0) && ((rem != 14'd0) || (q[1:0] == 2'd0));
  endfunction

  // days from jan 1 1601 to jan 1 of the year k years later, with q = k / 100
  function automatic logic [22:0] days_before(input logic [13:0] k, input logic [7:0] q);
    return 23'(k) * 23'd365 + 23'(k[13:2]) - 23'(q) + 23'(q[7:2]);
  endfunction

endpackage

FILE: rtl/gdn_encode.sv
// front pipeline: turns a date into a serial day number or passes a day number through
// depends on gdn_pkg; three register stages, each loaded when its enable is high
module gdn_encode (
  input  logic                           clk_i,
  input  logic [gdn_pkg::EncStages-1:0] en_i,
  input  logic                           kind_i,
  input  logic [21:0]                    day_number_i,
  input  logic [13:0]                    year_i,
  input  logic [3:0]                     month_i,
  input  logic [4:0]                     day_i,
  output logic [21:0]                    day_count_o
);
  import gdn_pkg::*;

  // stage 0
  logic        kind0_q, yok0_q, mge3_0_q;
  logic [21:0] dn_in0_q;
  logic [13:0] y0_q, k0_q;
  logic [8:0]  cum0_q;
  logic [4:0]  d0_q;
  logic [26:0] prodk0_q, prody0_q;
  logic [13:0] k0_d;

  // stage 1
  logic        kind1_q, yok1_q;
  logic [21:0] dn_in1_q;
  logic [22:0] dbf1_q, dbf1_d;
  logic [9:0]  add1_q, add1_d;
  logic        leap1_d;

  // stage 2
  logic [21:0] dn2_q, dn2_d;
  logic [22:0] sel2;

  assign k0_d = year_i - BaseYear;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      kind0_q  <= kind_i;
      dn_in0_q <= day_number_i;
      y0_q     <= year_i;
      k0_q     <= k0_d;
      yok0_q   <= (year_i >= BaseYear) && (year_i <= MaxYear);
      mge3_0_q <= month_i >= 4'd3;
      cum0_q   <= cum_days(month_i);
      d0_q     <= day_i;
      prodk0_q <= 27'(k0_d) * 27'(Recip100);
      prody0_q <= 27'(year_i) * 27'(Recip100);
    end
  end

  always_comb begin
    leap1_d = is_leap(y0_q, prody0_q[26:19]);
    dbf1_d  = days_before(k0_q, prodk0_q[26:19]);
    add1_d  = 10'(cum0_q) + 10'(d0_q) + 10'((leap1_d && mge3_0_q) ? 1 : 0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      kind1_q  <= kind0_q;
      dn_in1_q <= dn_in0_q;
      yok1_q   <= yok0_q;
      dbf1_q   <= dbf1_d;
      add1_q   <= add1_d;
    end
  end

  always_comb begin
    if (kind1_q) begin
      sel2 = 23'(dn_in1_q);
    end else if (yok1_q) begin
      sel2 = dbf1_q + 23'(add1_q);
    end else begin
      sel2 = 23'd0;
    end
    // anything past the last supported day is not a date
    dn2_d = (sel2 > LastDay) ? 22'd0 : sel2[21:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      dn2_q <= dn2_d;
    end
  end

  assign day_count_o = dn2_q;

endmodule

FILE: rtl/gdn_decode.sv
// back pipeline: splits a serial day number into year, month, day and weekday
// depends on gdn_pkg; eight register stages, the last one is the output register
module gdn_decode (
  input  logic                           clk_i,
  input  logic [gdn_pkg::DecStages-1:0] en_i,
  input  logic [21:0]                    day_count_i,
  output logic [21:0]                    day_count_o,
  output logic [13:0]                    year_o,
  output logic [3:0]                     month_o,
  output logic [4:0]                     day_of_month_o,
  output logic [8:0]                     day_of_year_o,
  output logic [2:0]                     weekday_o,
  output logic                           is_date_o
);
  import gdn_pkg::*;

  logic [21:0] r0_d;

  // stage 0: reciprocal products for the year estimate and the weekday
  logic [21:0] dn0_q, r0_q;
  logic [43:0] prode0_q;
  logic [44:0] prodw0_q;

  // stage 1
  logic [21:0] dn1_q, r1_q;
  logic [13:0] e1_1_q, e1_1_d;
  logic [26:0] prode1_1_q;
  logic [2:0]  wd1_q, wd1_d;
  logic [19:0] q7;

  // stage 2
  logic [21:0] dn2_q, r2_q;
  logic [13:0] e1_2_q;
  logic [22:0] dbfe1_2_q;
  logic        leape2_q;
  logic [2:0]  wd2_q;

  // stage 3
  logic [21:0] dn3_q;
  logic [2:0]  wd3_q;
  logic [13:0] year3_q, year3_d;
  logic [8:0]  doy3_q, doy3_d, diff3;
  logic        ge3;

  // stage 4
  logic [21:0] dn4_q;
  logic [2:0]  wd4_q;
  logic [13:0] year4_q;
  logic [8:0]  doy4_q;
  logic [26:0] prody4_q;

  // stage 5
  logic [21:0] dn5_q;
  logic [2:0]  wd5_q;
  logic [13:0] year5_q;
  logic [8:0]  doy5_q;
  logic        leap5_q;

  // stage 6
  logic [21:0] dn6_q;
  logic [2:0]  wd6_q;
  logic [13:0] year6_q;
  logic [8:0]  doy6_q;
  logic        leap6_q;
  logic [3:0]  month6_q, month6_d;

  // stage 7 (output)
  logic [21:0] dn7_q;
  logic [2:0]  wd7_q;
  logic [13:0] year7_q;
  logic [8:0]  doy7_q;
  logic [3:0]  month7_q;
  logic [4:0]  dom7_q;
  logic        ok7_q;
  logic        ok7_d;
  logic [8:0]  dom7_full;

  assign r0_d = day_count_i - 22'd1;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dn0_q    <= day_count_i;
      r0_q     <= r0_d;
      prode0_q <= 44'(r0_d) * 44'(RecipYear);
      prodw0_q <= 45'(day_count_i) * 45'(Recip7);
    end
  end

  // year estimate e is the true year index or one below; e1 = e + 1 is tested next
  always_comb begin
    e1_1_d = prode0_q[43:30] + 14'd1;
    q7     = prodw0_q[44:25];
    wd1_d  = 3'(dn0_q - 22'(q7) * 22'd7);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      dn1_q      <= dn0_q;
      r1_q       <= r0_q;
      e1_1_q     <= e1_1_d;
      prode1_1_q <= 27'(e1_1_d) * 27'(Recip100);
      wd1_q      <= wd1_d;
    end
  end

  // e1 also counts years from 1600, so it gives the leap test of year index e
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      dn2_q     <= dn1_q;
      r2_q      <= r1_q;
      e1_2_q    <= e1_1_q;
      dbfe1_2_q <= days_before(e1_1_q, prode1_1_q[26:19]);
      leape2_q  <= is_leap(e1_1_q, prode1_1_q[26:19]);
      wd2_q     <= wd1_q;
    end
  end

  always_comb begin
    ge3   = 23'(r2_q) >= dbfe1_2_q;
    diff3 = 9'(23'(r2_q) - dbfe1_2_q);
    if (ge3) begin
      year3_d = BaseYear + e1_2_q;
      doy3_d  = diff3 + 9'd1;
    end else begin
      // step back one year: add the length of year e
      year3_d = BaseYear + e1_2_q - 14'd1;
      doy3_d  = diff3 + 9'd366 + 9'(leape2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      dn3_q   <= dn2_q;
      wd3_q   <= wd2_q;
      year3_q <= year3_d;
      doy3_q  <= doy3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      dn4_q    <= dn3_q;
      wd4_q    <= wd3_q;
      year4_q  <= year3_q;
      doy4_q   <= doy3_q;
      prody4_q <= 27'(year3_q) * 27'(Recip100);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      dn5_q   <= dn4_q;
      wd5_q   <= wd4_q;
      year5_q <= year4_q;
      doy5_q  <= doy4_q;
      leap5_q <= is_leap(year4_q, prody4_q[26:19]);
    end
  end

  // month is one plus the number of month starts the day of year lies beyond
  always_comb begin
    month6_d = 4'd1;
    for (int i = 2; i <= 12; i++) begin
      if (doy5_q > cum_days_leap(4'(i), leap5_q)) begin
        month6_d = month6_d + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      dn6_q    <= dn5_q;
      wd6_q    <= wd5_q;
      year6_q  <= year5_q;
      doy6_q   <= doy5_q;
      leap6_q  <= leap5_q;
      month6_q <= month6_d;
    end
  end

  assign ok7_d     = dn6_q != 22'd0;
  assign dom7_full = doy6_q - cum_days_leap(month6_q, leap6_q);

  // not a date: every field reads zero
  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      dn7_q    <= dn6_q;
      wd7_q    <= wd6_q;
      ok7_q    <= ok7_d;
      year7_q  <= ok7_d ? year6_q : 14'd0;
      doy7_q   <= ok7_d ? doy6_q : 9'd0;
      month7_q <= ok7_d ? month6_q : 4'd0;
      dom7_q   <= ok7_d ? dom7_full[4:0] : 5'd0;
    end
  end

  assign day_count_o    = dn7_q;
  assign year_o         = year7_q;
  assign month_o        = month7_q;
  assign day_of_month_o = dom7_q;
  assign day_of_year_o  = doy7_q;
  assign weekday_o      = wd7_q;
  assign is_date_o      = ok7_q;

endmodule

FILE: rtl/gregorian_day_number_convert.sv
// Gregorian day number converter: one word in, one word out, eleven register stages, and a
// new word can enter every cycle while the output side is not stalling.
// The depth comes from the chain of reciprocal multiplications (year estimate, hundreds
// for the leap rule, weekday) that each get a stage of their own. Day 1 is Jan 1 1601;
// tuser in selects the direction (0 date to day number, 1 day number to date), tuser out
// is set when the result is a real date. Each stage holds while the next one is full and
// stalled, so bubbles close up and nothing is dropped or repeated.
// depends on gdn_pkg, gdn_encode, gdn_decode
module gregorian_day_number_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // day_number[21:0], year_in[35:22], month_in[39:36], day_in[44:40], zero fill
  input  logic [47:0] s_axis_tdata_i,
  // kind
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // day_count[21:0], year_out[35:22], month_out[39:36], day_of_month[44:40],
  // day_of_year[53:45], weekday[56:54], zero fill
  output logic [63:0] m_axis_tdata_o,
  // is_date
  output logic        m_axis_tuser_o
);
  import gdn_pkg::*;

  logic [NStages-1:0] vld_q, vld_d, en;
  logic [21:0]        enc_dn;
  logic [21:0]        day_count;
  logic [13:0]        year_out;
  logic [3:0]         month_out;
  logic [4:0]         day_of_month;
  logic [8:0]         day_of_year;
  logic [2:0]         weekday;
  logic               is_date;

  // a stage loads when it is empty or the stage after it moves on
  always_comb begin
    en[NStages-1] = !vld_q[NStages-1] || m_axis_tready_i;
    for (int i = NStages - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = s_axis_tvalid_i;
    end
    for (int i = 1; i < NStages; i++) begin
      if (en[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  gdn_encode u_encode (
    .clk_i        (clk_i),
    .en_i         (en[EncStages-1:0]),
    .kind_i       (s_axis_tuser_i),
    .day_number_i (s_axis_tdata_i[21:0]),
    .year_i       (s_axis_tdata_i[35:22]),
    .month_i      (s_axis_tdata_i[39:36]),
    .day_i        (s_axis_tdata_i[44:40]),
    .day_count_o  (enc_dn)
  );

  gdn_decode u_decode (
    .clk_i          (clk_i),
    .en_i           (en[NStages-1:EncStages]),
    .day_count_i    (enc_dn),
    .day_count_o    (day_count),
    .year_o         (year_out),
    .month_o        (month_out),
    .day_of_month_o (day_of_month),
    .day_of_year_o  (day_of_year),
    .weekday_o      (weekday),
    .is_date_o      (is_date)
  );

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[NStages-1];
  assign m_axis_tdata_o  = {7'd0, weekday, day_of_year, day_of_month, month_out, year_out,
                            day_count};
  assign m_axis_tuser_o  = is_date;

endmodule

FILE: tb/sv/day_number_checker.sv
// checker for the gregorian day number converter: watches both stream channels,
// predicts each result word from the accepted input word and compares field by field
// depends on gdn_pkg for the supported year range
module day_number_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // day_number[21:0], year_in[35:22], month_in[39:36], day_in[44:40], zero fill
  input  logic [47:0] s_axis_tdata_i,
  // kind
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // day_count[21:0], year_out[35:22], month_out[39:36], day_of_month[44:40],
  // day_of_year[53:45], weekday[56:54], zero fill
  input  logic [63:0] m_axis_tdata_i,
  // is_date
  input  logic        m_axis_tuser_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned dates_o,
  output int unsigned encodes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FirstYear = gdn_pkg::BaseYearInt;
  localparam int unsigned LastYear  = gdn_pkg::MaxYearInt;
  localparam int unsigned DaysYear  = 365;
  localparam int unsigned Days4     = 4 * DaysYear + 1;
  localparam int unsigned Days100   = 25 * Days4 - 1;
  localparam int unsigned Days400   = 4 * Days100 + 1;
  localparam int unsigned PrintCap  = 40;

  typedef struct packed {
    logic [21:0] day_count;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [8:0]  yday;
    logic [2:0]  wday;
    logic        is_date;
  } date_word_t;

  date_word_t expected_dates[$];

  // the counters are two-state and start at zero

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    case (m)
      2:              return 28 + (is_leap_year(y) ? 1 : 0);
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  // days from the first supported jan 1 up to jan 1 of year y
  function automatic int unsigned days_to_jan1(input int unsigned y);
    int unsigned k;
    k = y - FirstYear;
    return Days400 * (k / 400) + Days100 * (k % 400 / 100) + Days4 * (k % 100 / 4)
         + DaysYear * (k % 4);
  endfunction

  function automatic date_word_t convert_date(input logic kind, input logic [21:0] serial,
                                              input logic [13:0] y, input logic [3:0] m,
                                              input logic [4:0] d);
    date_word_t  w;
    int unsigned dn, r, q400, c100, q4, c1, yr, mo, dom, i;
    w  = '0;
    dn = 0;
    if (kind) begin
      dn = serial;
    end else if (y >= FirstYear && y <= LastYear) begin
      dn = days_to_jan1(y);
      // months past twelve fall to the 31-day default
      for (i = 1; i < m; i++) dn += month_length(i, y);
      dn += d;
    end
    if (dn > days_to_jan1(LastYear + 1)) dn = 0;
    if (dn != 0) begin
      r    = dn - 1;
      q400 = r / Days400;
      r    = r % Days400;
      // last day of a 400-year cycle would otherwise land in a fifth century
      c100 = r / Days100;
      if (c100 > 3) c100 = 3;
      r    = r - c100 * Days100;
      q4   = r / Days4;
      r    = r % Days4;
      c1   = r / DaysYear;
      if (c1 > 3) c1 = 3;
      r    = r - c1 * DaysYear;
      yr   = FirstYear + 400 * q400 + 100 * c100 + 4 * q4 + c1;
      dom  = r + 1;
      mo   = 1;
      while (mo < 12 && dom > month_length(mo, yr)) begin
        dom -= month_length(mo, yr);
        mo++;
      end
      w.day_count = 22'(dn);
      w.year      = 14'(yr);
      w.month     = 4'(mo);
      w.mday      = 5'(dom);
      w.yday      = 9'(r + 1);
      w.wday      = 3'(dn % 7);
      w.is_date   = 1'b1;
    end
    return w;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatches_o++;
    if (mismatches_o <= PrintCap)
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk_i) begin : watch_words
    date_word_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_dates.push_back(convert_date(s_axis_tuser_i, s_axis_tdata_i[21:0],
                                              s_axis_tdata_i[35:22], s_axis_tdata_i[39:36],
                                              s_axis_tdata_i[44:40]));
        if (!s_axis_tuser_i) encodes_o++;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.day_count = m_axis_tdata_i[21:0];
        got.year      = m_axis_tdata_i[35:22];
        got.month     = m_axis_tdata_i[39:36];
        got.mday      = m_axis_tdata_i[44:40];
        got.yday      = m_axis_tdata_i[53:45];
        got.wday      = m_axis_tdata_i[56:54];
        got.is_date   = m_axis_tuser_i;
        if (expected_dates.size() == 0) begin
          flag_mismatch("word with nothing expected", got.day_count, 0);
        end else begin
          want = expected_dates.pop_front();
          checked_o++;
          if (want.is_date) dates_o++;
          if (got.day_count !== want.day_count)
            flag_mismatch("day_count", got.day_count, want.day_count);
          if (got.year !== want.year) flag_mismatch("year_out", got.year, want.year);
          if (got.month !== want.month) flag_mismatch("month_out", got.month, want.month);
          if (got.mday !== want.mday) flag_mismatch("day_of_month", got.mday, want.mday);
          if (got.yday !== want.yday) flag_mismatch("day_of_year", got.yday, want.yday);
          if (got.wday !== want.wday) flag_mismatch("weekday", got.wday, want.wday);
          if (got.is_date !== want.is_date)
            flag_mismatch("is_date", got.is_date, want.is_date);
        end
      end
      pending_o <= expected_dates.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
// top of the day number converter testbench: clock, reset, stimulus and verdict
// depends on gdn_pkg, gregorian_day_number_convert and day_number_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic        ToDayNumber = 1'b0;
  localparam logic        ToDate      = 1'b1;
  localparam int unsigned RandomWords = 1150;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned TailCycles  = 30;
  localparam int unsigned LastSerial  = gdn_pkg::LastDay;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  int unsigned mismatches, pending, checked, dates, encodes;
  int unsigned quiet_cycles = 0;
  logic        tx_steady    = 1'b0;
  logic        rx_steady    = 1'b0;

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  gregorian_day_number_convert u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  day_number_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .checked_o       (checked),
    .dates_o         (dates),
    .encodes_o       (encodes)
  );

  // valid drops here only when a gap is drawn, so back-to-back words keep it high
  task automatic send_word(input logic kind, input logic [21:0] serial,
                           input logic [13:0] yr, input logic [3:0] mo, input logic [4:0] dy);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, dy, mo, yr, serial};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // result side: random stalls per word, none while rx_steady is set
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("no word moved for %0d cycles, %0d results outstanding", quiet_cycles,
                 pending);
        $display("gregorian_day_number_convert verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned pick, span, serial_r;
    logic [21:0] serial;
    logic [13:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic        kind;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // day numbers around the range ends and the leap and century boundaries
    send_word(ToDate, 22'd0, '0, '0, '0);
    send_word(ToDate, 22'd1, '0, '0, '0);
    send_word(ToDate, 22'(LastSerial), '0, '0, '0);
    send_word(ToDate, 22'(LastSerial + 1), '0, '0, '0);
    send_word(ToDate, '1, '1, '1, '1);
    send_word(ToDate, 22'd146097, '0, '0, '0);
    send_word(ToDate, 22'd146098, '0, '0, '0);
    send_word(ToDate, 22'd1461, '0, '0, '0);
    send_word(ToDate, 22'd36524, '0, '0, '0);
    send_word(ToDate, 22'd365, '0, '0, '0);
    // dates: range ends, rollover, day and month zero, month past twelve, bad years
    send_word(ToDayNumber, '0, 14'd1601, 4'd1, 5'd1);
    send_word(ToDayNumber, '0, 14'd9999, 4'd12, 5'd31);
    send_word(ToDayNumber, '0, 14'd9999, 4'd13, 5'd1);
    send_word(ToDayNumber, '0, 14'd1601, 4'd1, 5'd0);
    send_word(ToDayNumber, '0, 14'd2000, 4'd2, 5'd29);
    send_word(ToDayNumber, '0, 14'd1900, 4'd2, 5'd29);
    send_word(ToDayNumber, '0, 14'd1600, 4'd1, 5'd1);
    send_word(ToDayNumber, '0, 14'd10000, 4'd1, 5'd1);
    send_word(ToDayNumber, '1, '1, '1, '1);
    send_word(ToDayNumber, '0, '0, '0, '0);
    send_word(ToDayNumber, '0, 14'd2024, 4'd0, 5'd15);
    send_word(ToDayNumber, '0, 14'd2020, 4'd15, 5'd31);
    send_word(ToDayNumber, '0, 14'd2000, 4'd12, 5'd31);
    send_word(ToDayNumber, '1, 14'd2001, 4'd3, 5'd1);

    // let the pipeline empty completely once before the random traffic
    drain_results();

    for (int unsigned i = 0; i < RandomWords; i++) begin
      tx_steady = (i % 200) >= 160;
      rx_steady = (i % 250) >= 200;
      if (i == RandomWords / 2) drain_results();
      // fields the selected direction ignores carry random bits
      serial = 22'($urandom);
      yr     = 14'($urandom);
      mo     = 4'($urandom);
      dy     = 5'($urandom);
      pick   = $urandom_range(0, 99);
      if (pick < 35) begin
        kind   = ToDate;
        serial = 22'($urandom_range(0, LastSerial));
      end else if (pick < 45) begin
        // just either side of a year, 4-year, century or 400-year boundary
        kind = ToDate;
        case ($urandom_range(0, 3))
          0:       span = 365;
          1:       span = 1461;
          2:       span = 36524;
          default: span = 146097;
        endcase
        serial_r = $urandom_range(1, LastSerial / span + 1) * span + $urandom_range(0, 2) - 1;
        serial   = 22'(serial_r);
      end else if (pick < 55) begin
        kind = ToDate;
      end else if (pick < 90) begin
        kind = ToDayNumber;
        yr   = 14'($urandom_range(gdn_pkg::BaseYearInt, gdn_pkg::MaxYearInt));
        mo   = 4'($urandom_range(1, 12));
        dy   = 5'($urandom_range(1, 31));
        if ($urandom_range(0, 4) == 0) begin
          mo = 4'd12;
          dy = 5'd31;
        end
      end else begin
        kind = ToDayNumber;
      end
      send_word(kind, serial, yr, mo, dy);
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    $display("sent %0d words: %0d dates to day numbers, %0d day numbers to dates",
             RandomWords + 24, encodes, RandomWords + 24 - encodes);
    $display("checked %0d results, %0d real dates, %0d mismatches", checked, dates,
             mismatches);
    if (mismatches == 0 && pending == 0)
      $display("gregorian_day_number_convert verification clean");
    else
      $display("gregorian_day_number_convert verification failed");
    $finish;
  end

endmodule
